// File: hdl/triangle_mixed_voronoi_area_macros.svh
// Assertion macros shared by the mixed Voronoi area block.
// Included by the files that carry concurrent checks; needs clk and arst_n in scope.
`ifndef TRIANGLE_MIXED_VORONOI_AREA_MACROS_SVH
`define TRIANGLE_MIXED_VORONOI_AREA_MACROS_SVH
`ifndef NO_ASSERTIONS
`define TMVA_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tmva check failed");
`define TMVA_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tmva check failed");
`else
`define TMVA_ASSERT_IMP(lbl, ante, cons)
`define TMVA_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// File: hdl/tmva_pkg.sv
// Widths, latencies and sideband types of the mixed Voronoi area pipeline.
// No dependencies; used by every module of the block.
`default_nettype none
package tmva_pkg;
	localparam int COORD_W   = 32;
	localparam int EDGE_W    = 33;
	localparam int PROD_W    = 66;
	localparam int DOT_W     = 67;
	localparam int NORM_W    = 66;
	localparam int MUL_IN_W  = 67;
	localparam int LIMB_W    = 22;
	localparam int MAG_W     = 3 * LIMB_W;
	localparam int PP_W      = 2 * LIMB_W;
	localparam int ROW_W     = 4 * LIMB_W + 2;
	localparam int MUL_OUT_W = 133;
	localparam int MUL_LAT   = 5;
	localparam int SQ_IN_W   = 132;
	localparam int ROOT_W    = 66;
	localparam int SQ_REM_W  = 134;
	localparam int NUM_W     = 133;
	localparam int DEN_SHIFT = 19;
	localparam int AREA_W    = 48;
	localparam int DIV_W     = 134;
	localparam logic [AREA_W-1:0] AREA_MAX = {AREA_W{1'b1}};

	typedef struct packed {
		logic [2:0][NUM_W-1:0] num;
		logic [2:0]            dneg;
	} side_t;
endpackage
`default_nettype wire

// File: hdl/tmva_mul.sv
// Five-stage signed multiplier built from 22-bit limb products.
// Depends on tmva_pkg for widths.
`default_nettype none
module tmva_mul (
	input  wire logic                                  clk,
	input  wire logic                                  en,
	input  wire logic signed [tmva_pkg::MUL_IN_W-1:0]  a,
	input  wire logic signed [tmva_pkg::MUL_IN_W-1:0]  b,
	output logic signed [tmva_pkg::MUL_OUT_W-1:0]      p
);
	localparam int L = tmva_pkg::LIMB_W;

	logic                          sgn_s1, sgn_s2, sgn_s3, sgn_s4;
	logic [tmva_pkg::MAG_W-1:0]    ma_s1, mb_s1;
	logic [tmva_pkg::PP_W-1:0]     pp_s2 [3][3];
	logic [tmva_pkg::ROW_W-1:0]    row_s3 [3];
	logic [tmva_pkg::SQ_IN_W-1:0]  mag_s4;
	logic [tmva_pkg::MUL_IN_W-1:0] abs_a, abs_b;
	logic [tmva_pkg::ROW_W-1:0]    row_c [3];
	logic [tmva_pkg::SQ_IN_W-1:0]  mag_c;
	logic [tmva_pkg::MUL_OUT_W-1:0] mag_ext;

	// Magnitudes stay below 2^66 for every operand this block feeds in.
	assign abs_a = a[tmva_pkg::MUL_IN_W-1] ? -a : a;
	assign abs_b = b[tmva_pkg::MUL_IN_W-1] ? -b : b;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			row_c[i] = {{(tmva_pkg::ROW_W-tmva_pkg::PP_W){1'b0}}, pp_s2[i][0]}
				+ ({{(tmva_pkg::ROW_W-tmva_pkg::PP_W){1'b0}}, pp_s2[i][1]} << L)
				+ ({{(tmva_pkg::ROW_W-tmva_pkg::PP_W){1'b0}}, pp_s2[i][2]} << (2 * L));
		end
		mag_c = {{(tmva_pkg::SQ_IN_W-tmva_pkg::ROW_W){1'b0}}, row_s3[0]}
			+ ({{(tmva_pkg::SQ_IN_W-tmva_pkg::ROW_W){1'b0}}, row_s3[1]} << L)
			+ ({{(tmva_pkg::SQ_IN_W-tmva_pkg::ROW_W){1'b0}}, row_s3[2]} << (2 * L));
	end

	assign mag_ext = {1'b0, mag_s4};

	always_ff @(posedge clk) begin
		if (en) begin
			sgn_s1 <= a[tmva_pkg::MUL_IN_W-1] ^ b[tmva_pkg::MUL_IN_W-1];
			ma_s1  <= abs_a[tmva_pkg::MAG_W-1:0];
			mb_s1  <= abs_b[tmva_pkg::MAG_W-1:0];
			sgn_s2 <= sgn_s1;
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					pp_s2[i][j] <= ma_s1[L*i +: L] * mb_s1[L*j +: L];
				end
			end
			sgn_s3 <= sgn_s2;
			row_s3 <= row_c;
			sgn_s4 <= sgn_s3;
			mag_s4 <= mag_c;
			p      <= sgn_s4 ? -mag_ext : mag_ext;
		end
	end
endmodule
`default_nettype wire

// File: hdl/tmva_sqrt.sv
// Integer square root, one result bit per pipeline stage, with sideband.
// Depends on tmva_pkg for widths and the sideband type.
`default_nettype none
module tmva_sqrt (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 en,
	input  wire logic                                 vin,
	input  wire logic [tmva_pkg::SQ_IN_W-1:0]         s_in,
	input  wire tmva_pkg::side_t                      side_in,
	output logic                                      vout,
	output logic [tmva_pkg::ROOT_W-1:0]               t_out,
	output tmva_pkg::side_t                           side_out
);
	localparam int N = tmva_pkg::ROOT_W;
	localparam int W = tmva_pkg::SQ_REM_W;

	logic                        v_s    [N];
	logic [W-1:0]                rem_s  [N];
	logic [N-1:0]                root_s [N];
	tmva_pkg::side_t             side_s [N];

	for (genvar j = 0; j < N; j++) begin : g_stage
		localparam int K = N - 1 - j;
		logic                v_i;
		logic [W-1:0]        rem_i, test_i;
		logic [N-1:0]        root_i;
		tmva_pkg::side_t     side_i;
		if (j == 0) begin : g_first
			assign v_i    = vin;
			assign rem_i  = {{(W-tmva_pkg::SQ_IN_W){1'b0}}, s_in};
			assign root_i = '0;
			assign side_i = side_in;
		end else begin : g_next
			assign v_i    = v_s[j-1];
			assign rem_i  = rem_s[j-1];
			assign root_i = root_s[j-1];
			assign side_i = side_s[j-1];
		end
		// (r + 2^k)^2 - r^2 with the low k+1 bits of r still clear.
		assign test_i = ({{(W-N){1'b0}}, root_i} << (K + 1))
			| ({{(W-1){1'b0}}, 1'b1} << (2 * K));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[j] <= 1'b0;
			end else if (en) begin
				v_s[j] <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[j] <= side_i;
				if (rem_i >= test_i) begin
					rem_s[j]  <= rem_i - test_i;
					root_s[j] <= root_i | ({{(N-1){1'b0}}, 1'b1} << K);
				end else begin
					rem_s[j]  <= rem_i;
					root_s[j] <= root_i;
				end
			end
		end
	end

	assign vout     = v_s[N-1];
	assign t_out    = root_s[N-1];
	assign side_out = side_s[N-1];
endmodule
`default_nettype wire

// File: hdl/tmva_div.sv
// Restoring divider for the three corners, one quotient bit per stage,
// with an overflow test up front. Depends on tmva_pkg.
`default_nettype none
module tmva_div (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   en,
	input  wire logic                                   vin,
	input  wire logic [tmva_pkg::ROOT_W-1:0]            t_in,
	input  wire tmva_pkg::side_t                        side_in,
	output logic                                        vout,
	output logic [tmva_pkg::ROOT_W-1:0]                 t_out,
	output logic [2:0]                                  dneg_out,
	output logic [2:0][tmva_pkg::AREA_W-1:0]            q_out,
	output logic [2:0]                                  ovf_out
);
	localparam int NS = tmva_pkg::AREA_W + 1;
	localparam int W  = tmva_pkg::DIV_W;
	localparam int QW = tmva_pkg::AREA_W;

	logic                        v_s    [NS];
	logic [tmva_pkg::ROOT_W-1:0] t_s    [NS];
	logic [2:0]                  dneg_s [NS];
	logic [2:0]                  ovf_s  [NS];
	logic [2:0][W-1:0]           rem_s  [NS];
	logic [2:0][QW-1:0]          q_s    [NS];

	logic [W-1:0] den0, lim0;
	assign den0 = {{(W-tmva_pkg::ROOT_W-tmva_pkg::DEN_SHIFT){1'b0}}, t_in,
		{tmva_pkg::DEN_SHIFT{1'b0}}};
	assign lim0 = den0 << QW;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= vin;
		end
	end

	// The quotient fits the area width exactly when num < den * 2^width.
	always_ff @(posedge clk) begin
		if (en) begin
			t_s[0]    <= t_in;
			dneg_s[0] <= side_in.dneg;
			q_s[0]    <= '0;
			for (int l = 0; l < 3; l++) begin
				rem_s[0][l] <= {{(W-tmva_pkg::NUM_W){1'b0}}, side_in.num[l]};
				ovf_s[0][l] <= {{(W-tmva_pkg::NUM_W){1'b0}}, side_in.num[l]} >= lim0;
			end
		end
	end

	for (genvar j = 1; j < NS; j++) begin : g_stage
		localparam int K = NS - 1 - j;
		logic [W-1:0] sh_i;
		assign sh_i = {{(W-tmva_pkg::ROOT_W-tmva_pkg::DEN_SHIFT){1'b0}}, t_s[j-1],
			{tmva_pkg::DEN_SHIFT{1'b0}}} << K;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[j] <= 1'b0;
			end else if (en) begin
				v_s[j] <= v_s[j-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				t_s[j]    <= t_s[j-1];
				dneg_s[j] <= dneg_s[j-1];
				ovf_s[j]  <= ovf_s[j-1];
				for (int l = 0; l < 3; l++) begin
					if (rem_s[j-1][l] >= sh_i) begin
						rem_s[j][l] <= rem_s[j-1][l] - sh_i;
						q_s[j][l]   <= q_s[j-1][l] | ({{(QW-1){1'b0}}, 1'b1} << K);
					end else begin
						rem_s[j][l] <= rem_s[j-1][l];
						q_s[j][l]   <= q_s[j-1][l];
					end
				end
			end
		end
	end

	assign vout     = v_s[NS-1];
	assign t_out    = t_s[NS-1];
	assign dneg_out = dneg_s[NS-1];
	assign q_out    = q_s[NS-1];
	assign ovf_out  = ovf_s[NS-1];
endmodule
`default_nettype wire

// File: hdl/triangle_mixed_voronoi_area.sv
// Top level of the mixed Voronoi corner area pipeline.
// Depends on tmva_pkg, tmva_mul, tmva_sqrt, tmva_div and the assertion macros.
//
//  channel | direction | handshake             | word
//  input   | in        | in_valid / in_stall   | p0_x .. p2_z, signed Q16.16
//  output  | out       | out_valid / out_stall | area_corner0..2, degenerate, saturated
//
// One triangle enters per cycle while in_stall is low. Four front stages, a five-stage
// limb multiplier, a sum stage, 66 square-root stages, 49 divider stages and the output
// register follow; each root stage and each divider stage past the first yields one bit.
// Reset clears every valid bit; the data path holds no state that needs clearing.
// out_stall with a word waiting freezes the whole pipeline, and in_stall follows it.
`default_nettype none
`include "triangle_mixed_voronoi_area_macros.svh"
module triangle_mixed_voronoi_area (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic signed [tmva_pkg::COORD_W-1:0] p0_x,
	input  wire logic signed [tmva_pkg::COORD_W-1:0] p0_y,
	input  wire logic signed [tmva_pkg::COORD_W-1:0] p0_z,
	input  wire logic signed [tmva_pkg::COORD_W-1:0] p1_x,
	input  wire logic signed [tmva_pkg::COORD_W-1:0] p1_y,
	input  wire logic signed [tmva_pkg::COORD_W-1:0] p1_z,
	input  wire logic signed [tmva_pkg::COORD_W-1:0] p2_x,
	input  wire logic signed [tmva_pkg::COORD_W-1:0] p2_y,
	input  wire logic signed [tmva_pkg::COORD_W-1:0] p2_z,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic [tmva_pkg::AREA_W-1:0]              area_corner0,
	output logic [tmva_pkg::AREA_W-1:0]              area_corner1,
	output logic [tmva_pkg::AREA_W-1:0]              area_corner2,
	output logic                                     degenerate,
	output logic                                     saturated
);
	localparam int AW = tmva_pkg::AREA_W;
	localparam int RW = tmva_pkg::ROOT_W;

	logic en;
	logic signed [tmva_pkg::COORD_W-1:0] p_in [3][3];

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic signed [tmva_pkg::COORD_W-1:0] p_s1 [3][3];
	logic signed [tmva_pkg::EDGE_W-1:0]  e_s2 [3][3];
	logic signed [tmva_pkg::PROD_W-1:0]  xa_s3 [3], xb_s3 [3];
	logic signed [tmva_pkg::PROD_W-1:0]  dp_s3 [3][3], np_s3 [3][3];
	logic signed [tmva_pkg::PROD_W-1:0]  c_s4 [3];
	logic signed [tmva_pkg::DOT_W-1:0]   d_s4 [3];
	logic [tmva_pkg::NORM_W-1:0]         n_s4 [3];

	logic signed [tmva_pkg::MUL_IN_W-1:0]  sq_in [3], na_a [3], na_b [3], nb_a [3], nb_b [3];
	logic signed [tmva_pkg::MUL_OUT_W-1:0] sq_p [3], na_p [3], nb_p [3];
	logic        vm_s    [tmva_pkg::MUL_LAT];
	logic [2:0]  dnm_s   [tmva_pkg::MUL_LAT];

	logic [tmva_pkg::SQ_IN_W-1:0]   s_s5;
	tmva_pkg::side_t                side_s5;
	logic [tmva_pkg::MUL_OUT_W+1:0] sum_s, num_c [3];

	logic                sq_v;
	logic [RW-1:0]       sq_t;
	tmva_pkg::side_t     sq_side;
	logic                dv_v;
	logic [RW-1:0]       dv_t;
	logic [2:0]          dv_dneg, dv_ovf;
	logic [2:0][AW-1:0]  dv_q;

	logic                out_valid_q, degen_q, sat_q;
	logic [AW-1:0]       area_q [3];
	logic [AW-1:0]       area_c [3];
	logic                degen_c, sat_c, obt_c;

	assign en       = !out_valid_q || !out_stall;
	assign in_stall = !en;

	assign p_in[0][0] = p0_x; assign p_in[0][1] = p0_y; assign p_in[0][2] = p0_z;
	assign p_in[1][0] = p1_x; assign p_in[1][1] = p1_y; assign p_in[1][2] = p1_z;
	assign p_in[2][0] = p2_x; assign p_in[2][1] = p2_y; assign p_in[2][2] = p2_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			for (int i = 0; i < tmva_pkg::MUL_LAT; i++) begin
				vm_s[i] <= 1'b0;
			end
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			vm_s[0] <= v_s4;
			for (int i = 1; i < tmva_pkg::MUL_LAT; i++) begin
				vm_s[i] <= vm_s[i-1];
			end
			v_s5 <= vm_s[tmva_pkg::MUL_LAT-1];
			out_valid_q <= dv_v;
		end
	end

	// Front end: edges, then all 33x33 products, then the cross, dot and norm sums.
	always_ff @(posedge clk) begin
		if (en) begin
			p_s1 <= p_in;
			for (int i = 0; i < 3; i++) begin
				for (int k = 0; k < 3; k++) begin
					e_s2[i][k] <= p_s1[(i + 1) % 3][k] - p_s1[i][k];
				end
			end
			for (int k = 0; k < 3; k++) begin
				xa_s3[k] <= e_s2[0][(k + 1) % 3] * e_s2[1][(k + 2) % 3];
				xb_s3[k] <= e_s2[0][(k + 2) % 3] * e_s2[1][(k + 1) % 3];
			end
			for (int i = 0; i < 3; i++) begin
				for (int k = 0; k < 3; k++) begin
					dp_s3[i][k] <= e_s2[i][k] * e_s2[(i + 2) % 3][k];
					np_s3[i][k] <= e_s2[i][k] * e_s2[i][k];
				end
			end
			for (int i = 0; i < 3; i++) begin
				c_s4[i] <= xa_s3[i] - xb_s3[i];
				d_s4[i] <= -(dp_s3[i][0] + dp_s3[i][1] + dp_s3[i][2]);
				n_s4[i] <= np_s3[i][0] + np_s3[i][1] + np_s3[i][2];
			end
			dnm_s[0] <= {d_s4[2][tmva_pkg::DOT_W-1], d_s4[1][tmva_pkg::DOT_W-1],
				d_s4[0][tmva_pkg::DOT_W-1]};
			for (int i = 1; i < tmva_pkg::MUL_LAT; i++) begin
				dnm_s[i] <= dnm_s[i-1];
			end
		end
	end

	for (genvar i = 0; i < 3; i++) begin : g_mul
		assign sq_in[i] = {c_s4[i][tmva_pkg::PROD_W-1], c_s4[i]};
		assign na_a[i]  = {1'b0, n_s4[i]};
		assign na_b[i]  = d_s4[(i + 2) % 3];
		assign nb_a[i]  = {1'b0, n_s4[(i + 2) % 3]};
		assign nb_b[i]  = d_s4[(i + 1) % 3];

		tmva_mul u_sq (.clk(clk), .en(en), .a(sq_in[i]), .b(sq_in[i]), .p(sq_p[i]));
		tmva_mul u_na (.clk(clk), .en(en), .a(na_a[i]), .b(na_b[i]), .p(na_p[i]));
		tmva_mul u_nb (.clk(clk), .en(en), .a(nb_a[i]), .b(nb_b[i]), .p(nb_p[i]));

		assign num_c[i] = {{2{na_p[i][tmva_pkg::MUL_OUT_W-1]}}, na_p[i]}
			+ {{2{nb_p[i][tmva_pkg::MUL_OUT_W-1]}}, nb_p[i]};
	end

	assign sum_s = {2'b00, sq_p[0]} + {2'b00, sq_p[1]} + {2'b00, sq_p[2]};

	always_ff @(posedge clk) begin
		if (en) begin
			s_s5 <= sum_s[tmva_pkg::SQ_IN_W-1:0];
			for (int i = 0; i < 3; i++) begin
				side_s5.num[i] <= num_c[i][tmva_pkg::NUM_W-1:0];
			end
			side_s5.dneg <= dnm_s[tmva_pkg::MUL_LAT-1];
		end
	end

	tmva_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .en(en),
		.vin(v_s5), .s_in(s_s5), .side_in(side_s5),
		.vout(sq_v), .t_out(sq_t), .side_out(sq_side)
	);

	tmva_div u_div (
		.clk(clk), .arst_n(arst_n), .en(en),
		.vin(sq_v), .t_in(sq_t), .side_in(sq_side),
		.vout(dv_v), .t_out(dv_t), .dneg_out(dv_dneg), .q_out(dv_q), .ovf_out(dv_ovf)
	);

	// An obtuse corner takes half of the area, the other two a quarter.
	always_comb begin
		degen_c = (dv_t == '0);
		obt_c   = |dv_dneg;
		sat_c   = 1'b0;
		for (int i = 0; i < 3; i++) begin
			if (degen_c) begin
				area_c[i] = '0;
			end else if (dv_dneg[i]) begin
				area_c[i] = dv_t[RW-1 -: AW];
			end else if (obt_c) begin
				area_c[i] = {1'b0, dv_t[RW-1 -: AW-1]};
			end else if (dv_ovf[i]) begin
				area_c[i] = tmva_pkg::AREA_MAX;
				sat_c     = 1'b1;
			end else begin
				area_c[i] = dv_q[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			area_q  <= area_c;
			degen_q <= degen_c;
			sat_q   <= sat_c;
		end
	end

	assign out_valid    = out_valid_q;
	assign area_corner0 = area_q[0];
	assign area_corner1 = area_q[1];
	assign area_corner2 = area_q[2];
	assign degenerate   = degen_q;
	assign saturated    = sat_q;

	`TMVA_ASSERT_IMP(a_degen_zero, out_valid && degenerate,
		area_corner0 == '0 && area_corner1 == '0 && area_corner2 == '0 && !saturated)
	`TMVA_ASSERT_IMP(a_sat_has_max, out_valid && saturated,
		!degenerate && (area_corner0 == tmva_pkg::AREA_MAX ||
		area_corner1 == tmva_pkg::AREA_MAX || area_corner2 == tmva_pkg::AREA_MAX))
	`TMVA_ASSERT_NXT(a_drain_empty, out_valid && !out_stall && !dv_v, !out_valid)
endmodule
`default_nettype wire
